>>> design/tlvp_pkg.sv
// Shared types and constants for the TLV configuration stream parser.
// No dependencies; the parser, input register and parse core files import this package.
package tlvp_pkg;

	localparam logic [7:0]  MAGIC_0         = 8'hCF;
	localparam logic [7:0]  MAGIC_1         = 8'h01;
	localparam logic [15:0] MAX_VERSION     = 16'd3;
	localparam logic [2:0]  HEADER_LAST_POS = 3'd5;  // header is six bytes
	localparam logic [2:0]  ENTRY_LAST_POS  = 3'd4;  // entry header is five bytes
	localparam logic [2:0]  MAGIC_0_POS     = 3'd0;
	localparam logic [2:0]  MAGIC_1_POS     = 3'd1;
	localparam logic [2:0]  VERSION_POS     = 3'd3;
	localparam logic [2:0]  KEY_POS         = 3'd1;
	localparam logic [2:0]  TYPE_POS        = 3'd2;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC   = 2'd1;
	localparam logic [1:0] ST_BAD_VERSION = 2'd2;
	localparam logic [1:0] ST_TRUNCATED   = 2'd3;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_ENTRY,
		PH_VALUE,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic        value_valid;
		logic [15:0] key_id;
		logic [7:0]  entry_type;
		logic [7:0]  value_byte;
		logic [15:0] value_index;
		logic        entry_done;
		logic        parse_done;
		logic [1:0]  status_code;
	} out_item_t;

endpackage

>>> design/tlvp_stream_if.sv
// Valid/ready stream channel carrying one payload item per handshake.
// The payload type is a parameter; the block uses the item types of tlvp_pkg.
interface tlvp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> design/tlv_config_stream_parser.sv
// TLV configuration stream parser. Takes one buffer byte per item and returns
// exactly one result item per input item, one item per cycle while the output
// is ready; each item passes the input register, then parse logic into the
// result register, and input ready follows output ready through the
// result register's hold path. A buffer starts with magic CF 01, a version of
// at most 3 and an entry count; each entry's value bytes come out with key,
// type and index, entry_done marks entry ends and parse_done/status_code give
// the final status. After end_of_buffer the parser expects a new header.
module tlv_config_stream_parser (
	input logic          clk,
	input logic          arst_n,
	tlvp_stream_if.sink   byte_stream,
	tlvp_stream_if.source parse_result
);
	import tlvp_pkg::*;

	logic      take_s1;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t res_s2;

	tlvp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_stream.valid),
		.in_ready (byte_stream.ready),
		.in_item  (byte_stream.payload),
		.take_s1  (take_s1),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tlvp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.take_s1   (take_s1),
		.valid_s2  (valid_s2),
		.res_s2    (res_s2),
		.out_ready (parse_result.ready)
	);

	assign parse_result.valid   = valid_s2;
	assign parse_result.payload = res_s2;

endmodule

>>> design/tlvp_in_reg.sv
// Input register stage: captures one input item per handshake.
// Depends on tlvp_pkg for the input item type.
module tlvp_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tlvp_pkg::in_item_t in_item,
	input  logic               take_s1,
	output logic               valid_s1,
	output tlvp_pkg::in_item_t item_s1
);
	import tlvp_pkg::*;

	// free when empty or when the held item moves on this cycle
	assign in_ready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> design/tlvp_parse_core.sv
// Parser state machine and result register.
// Consumes the registered input item, updates header/entry/value tracking
// and registers one result item. Depends on tlvp_pkg.
module tlvp_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  tlvp_pkg::in_item_t  item_s1,
	output logic                take_s1,
	output logic                valid_s2,
	output tlvp_pkg::out_item_t res_s2,
	input  logic                out_ready
);
	import tlvp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  pos_q, pos_d;
	logic [15:0] field_q, field_d;
	logic [15:0] expected_q, expected_d;
	logic [15:0] seen_q, seen_d;
	logic [15:0] key_q, key_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] remaining_q, remaining_d;
	logic [15:0] index_q, index_d;
	out_item_t   res;

	assign take_s1 = valid_s1 && (!valid_s2 || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			pos_q       <= '0;
			field_q     <= '0;
			expected_q  <= '0;
			seen_q      <= '0;
			key_q       <= '0;
			type_q      <= '0;
			remaining_q <= '0;
			index_q     <= '0;
		end else if (take_s1) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			field_q     <= field_d;
			expected_q  <= expected_d;
			seen_q      <= seen_d;
			key_q       <= key_d;
			type_q      <= type_d;
			remaining_q <= remaining_d;
			index_q     <= index_d;
		end
	end

	always_comb begin
		logic [15:0] shifted;
		logic        fin;
		logic [1:0]  fin_status;
		logic        complete;
		logic [7:0]  b;

		b          = item_s1.data_byte;
		shifted    = {field_q[7:0], b};
		fin        = 1'b0;
		fin_status = ST_OK;
		complete   = 1'b0;

		phase_d     = phase_q;
		pos_d       = pos_q;
		field_d     = field_q;
		expected_d  = expected_q;
		seen_d      = seen_q;
		key_d       = key_q;
		type_d      = type_q;
		remaining_d = remaining_q;
		index_d     = index_q;
		res         = '0;

		case (phase_q)
			PH_HEADER: begin
				field_d = shifted;
				if (pos_q == MAGIC_0_POS && b != MAGIC_0) begin
					fin        = 1'b1;
					fin_status = ST_BAD_MAGIC;
				end else if (pos_q == MAGIC_1_POS && b != MAGIC_1) begin
					fin        = 1'b1;
					fin_status = ST_BAD_MAGIC;
				end else if (pos_q == VERSION_POS && shifted > MAX_VERSION) begin
					fin        = 1'b1;
					fin_status = ST_BAD_VERSION;
				end else if (pos_q >= HEADER_LAST_POS) begin
					expected_d = shifted;
					seen_d     = '0;
					pos_d      = '0;
					if (shifted == '0) begin
						fin = 1'b1;
					end else begin
						phase_d = PH_ENTRY;
					end
				end else begin
					pos_d = pos_q + 3'd1;
				end
			end
			PH_ENTRY: begin
				field_d = shifted;
				if (pos_q == KEY_POS) begin
					key_d = shifted;
				end else if (pos_q == TYPE_POS) begin
					type_d = b;
				end
				if (pos_q >= ENTRY_LAST_POS) begin
					remaining_d = shifted;
					index_d     = '0;
					pos_d       = '0;
					if (shifted == '0) begin
						complete = 1'b1;
					end else begin
						phase_d = PH_VALUE;
					end
				end else begin
					pos_d = pos_q + 3'd1;
				end
			end
			PH_VALUE: begin
				res.value_valid = 1'b1;
				res.value_byte  = b;
				res.value_index = index_q;
				index_d         = index_q + 16'd1;
				remaining_d     = remaining_q - 16'd1;
				if (remaining_d == '0) begin
					complete = 1'b1;
				end
			end
			default: begin
				// skip phase: drop bytes until end of buffer
			end
		endcase

		if (complete) begin
			res.entry_done = 1'b1;
			seen_d         = seen_q + 16'd1;
			pos_d          = '0;
			if (seen_d == expected_q) begin
				fin = 1'b1;
			end else begin
				phase_d = PH_ENTRY;
			end
		end

		if (fin) begin
			res.parse_done  = 1'b1;
			res.status_code = fin_status;
			phase_d         = PH_SKIP;
			pos_d           = '0;
		end

		// end of buffer: flag an unfinished parse and rearm for the next one
		if (item_s1.end_of_buffer) begin
			if (phase_d != PH_SKIP) begin
				res.parse_done  = 1'b1;
				res.status_code = ST_TRUNCATED;
			end
			phase_d = PH_HEADER;
			pos_d   = '0;
			field_d = '0;
		end

		if (res.value_valid || res.entry_done) begin
			res.key_id     = key_d;
			res.entry_type = type_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			res_s2 <= res;
		end
	end

	a_eob_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && item_s1.end_of_buffer |=> phase_q == PH_HEADER && pos_q == '0)
		else $error("parser not back in header phase after end of buffer");

	a_value_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_VALUE |-> remaining_q != '0)
		else $error("value phase with no bytes remaining");

	a_entry_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ENTRY |-> pos_q <= ENTRY_LAST_POS)
		else $error("entry header position out of range");

	a_value_no_header_err: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.value_valid || res_s2.entry_done) |->
		!(res_s2.status_code == ST_BAD_MAGIC || res_s2.status_code == ST_BAD_VERSION))
		else $error("entry output together with a header error");

	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.parse_done |-> res_s2.status_code == ST_OK)
		else $error("status code set without parse_done");

endmodule
